// ===== sv/swso_pkg.sv =====
// Shared types and constants for the sliding-window stillness offset block.
// No dependencies; used by every module of the block by scoped names.
package swso_pkg;

  localparam int COORD_W = 24;
  localparam int OFF_W   = 25;
  localparam int ROW_W   = 3 * COORD_W;
  localparam int LEN_W   = 5;
  localparam int THR_W   = 23;
  localparam int MUL_W   = 32;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic REG_WINDOW_LEN      = 1'b0;
  localparam logic REG_STILL_THRESHOLD = 1'b1;

  localparam logic [LEN_W-1:0] WINDOW_LEN_RST      = 5'd16;
  localparam logic [THR_W-1:0] STILL_THRESHOLD_RST = 23'd655;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OFF_W-1:0]   offset_t;
  typedef logic [MUL_W-1:0]          mul_op_t;
  typedef logic [PROD_W-1:0]         prod_t;
  typedef logic [ROW_W-1:0]          row_t;

endpackage

// ===== sv/swso_ram.sv =====
// Window point store: one write port, one registered read port.
// Uses swso_pkg for the row type.
module swso_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  swso_pkg::row_t   wdata,
  input  logic [AW-1:0]    raddr,
  output swso_pkg::row_t   rdata_r
);

  swso_pkg::row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

// ===== sv/swso_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
// Uses swso_pkg for operand and product types.
module swso_mul (
  input  logic              clk,
  input  swso_pkg::mul_op_t mul_a,
  input  swso_pkg::mul_op_t mul_b,
  output swso_pkg::prod_t   prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= swso_pkg::PROD_W'(mul_a) * swso_pkg::PROD_W'(mul_b);
  end

endmodule

// ===== sv/sliding_window_stillness_offset.sv =====
// A request that leaves the window not yet full goes straight to the result state;
// when the window of L points is evaluated, its duration is set by the shared
// multiplier taking one square per cycle over every window point and axis.
// Throughput: one request at a time; the next is taken the cycle after the result
// enters the output register.
// Synchronous reset clears the count, offsets and output, loads register defaults.
module sliding_window_stillness_offset #(
  parameter int WINDOW = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [swso_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [swso_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [swso_pkg::COORD_W-1:0] in_point_z,
  input  logic signed [swso_pkg::COORD_W-1:0] in_robot_x,
  input  logic signed [swso_pkg::COORD_W-1:0] in_robot_y,
  input  logic signed [swso_pkg::COORD_W-1:0] in_robot_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_offset_updated,
  output logic signed [swso_pkg::OFF_W-1:0]   out_offset_x,
  output logic signed [swso_pkg::OFF_W-1:0]   out_offset_y,
  output logic signed [swso_pkg::OFF_W-1:0]   out_offset_z,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [swso_pkg::CFG_AW-1:0]         paddr,
  input  logic [swso_pkg::CFG_DW-1:0]         pwdata,
  output logic [swso_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW  = $clog2(WINDOW + 1);
  localparam int S1W = 25 + $clog2(WINDOW);
  localparam int S2W = 47 + $clog2(WINDOW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LIM0 = 4'd1;
  localparam logic [3:0] S_LIM1 = 4'd2;
  localparam logic [3:0] S_LIM2 = 4'd3;
  localparam logic [3:0] S_LIM3 = 4'd4;
  localparam logic [3:0] S_LIM4 = 4'd5;
  localparam logic [3:0] S_SQ   = 4'd6;
  localparam logic [3:0] S_F0   = 4'd7;
  localparam logic [3:0] S_F1   = 4'd8;
  localparam logic [3:0] S_F2   = 4'd9;
  localparam logic [3:0] S_F3   = 4'd10;
  localparam logic [3:0] S_F4   = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]                    state_r, state_nxt;
  logic [swso_pkg::LEN_W-1:0]    window_len_r;
  logic [swso_pkg::THR_W-1:0]    thresh_r;
  logic [CW-1:0]                 fill_r;
  logic [IW-1:0]                 oldest_r;
  swso_pkg::offset_t             off_x_r, off_y_r, off_z_r;
  logic                          out_valid_r, upd_r, still_r, acc_en_r;
  logic [1:0]                    acc_sel_r;

  swso_pkg::coord_t              pt_x_r, pt_y_r, pt_z_r, rb_x_r, rb_y_r, rb_z_r;
  logic [CW-1:0]                 len_r, cnt_r;
  logic [IW-1:0]                 rd_addr_r, rd_addr_nxt;
  logic [1:0]                    sub_r, axis_r;
  logic signed [S1W-1:0]         s1_r [3];
  logic [S2W-1:0]                s2_r [3];
  logic [45:0]                   tt_r;
  logic [15:0]                   nn_r;
  logic [63:0]                   lim_r, cmp_r, sp_r;

  swso_pkg::mul_op_t             mul_a, mul_b;
  swso_pkg::prod_t               prod_r;
  swso_pkg::row_t                row_r;

  logic                          accept, evaluate, out_free, last_elem;
  logic [CW-1:0]                 len_eff, fill_add, len_m1;
  logic [IW:0]                   wslot_sum, old2_sum, old3_sum, win_ext;
  logic [IW-1:0]                 wslot, oldest2, oldest3;
  swso_pkg::coord_t              v_s;
  logic [swso_pkg::COORD_W-1:0]  v_mag;
  logic signed [S1W-1:0]         s1_sel;
  logic [S1W-1:0]                s1_mag;
  swso_pkg::mul_op_t             a1;

  // Configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == swso_pkg::REG_WINDOW_LEN) ?
                  swso_pkg::CFG_DW'(window_len_r) : swso_pkg::CFG_DW'(thresh_r);

  always_comb begin
    if (window_len_r < 5'd2) begin
      len_eff = CW'(2);
    end else if (32'(window_len_r) > WINDOW) begin
      len_eff = CW'(WINDOW);
    end else begin
      len_eff = CW'(window_len_r);
    end
  end

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign fill_add  = fill_r + CW'(1);
  assign evaluate  = (fill_add >= len_eff);
  assign out_free  = !out_valid_r || !out_stall;
  assign len_m1    = len_r - CW'(1);
  assign last_elem = (sub_r == 2'd2) && (cnt_r == len_m1);
  assign win_ext   = (IW + 1)'(WINDOW);

  assign wslot_sum = {1'b0, oldest_r} + (IW + 1)'(fill_r);
  assign wslot     = (wslot_sum >= win_ext) ? IW'(wslot_sum - win_ext) : IW'(wslot_sum);
  assign old2_sum  = {1'b0, oldest_r} + (IW + 1)'(fill_add - len_eff);
  assign oldest2   = (old2_sum >= win_ext) ? IW'(old2_sum - win_ext) : IW'(old2_sum);
  assign old3_sum  = {1'b0, oldest2} + (IW + 1)'(1);
  assign oldest3   = (old3_sum >= win_ext) ? IW'(old3_sum - win_ext) : IW'(old3_sum);

  always_comb begin
    case (sub_r)
      2'd0:    v_s = row_r[23:0];
      2'd1:    v_s = row_r[47:24];
      default: v_s = row_r[71:48];
    endcase
  end
  assign v_mag  = v_s[swso_pkg::COORD_W-1] ? -v_s : v_s;
  assign s1_sel = s1_r[axis_r];
  assign s1_mag = s1_sel[S1W-1] ? -s1_sel : s1_sel;
  assign a1     = swso_pkg::MUL_W'(s1_mag[S1W-2:0]);

  always_comb begin
    rd_addr_nxt = rd_addr_r;
    if (accept && evaluate) begin
      rd_addr_nxt = oldest2;
    end else if (state_r == S_SQ && sub_r == 2'd2 && !last_elem) begin
      rd_addr_nxt = (rd_addr_r == IW'(WINDOW - 1)) ? '0 : rd_addr_r + IW'(1);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_LIM0: begin
        mul_a = swso_pkg::MUL_W'(thresh_r);
        mul_b = swso_pkg::MUL_W'(thresh_r);
      end
      S_LIM1: begin
        mul_a = swso_pkg::MUL_W'(len_r);
        mul_b = swso_pkg::MUL_W'(len_m1);
      end
      S_LIM2: begin
        mul_a = tt_r[31:0];
        mul_b = swso_pkg::MUL_W'(prod_r[15:0]);
      end
      S_LIM3: begin
        mul_a = swso_pkg::MUL_W'(tt_r[45:32]);
        mul_b = swso_pkg::MUL_W'(nn_r);
      end
      S_SQ: begin
        mul_a = swso_pkg::MUL_W'(v_mag);
        mul_b = swso_pkg::MUL_W'(v_mag);
      end
      S_F0: begin
        mul_a = a1;
        mul_b = a1;
      end
      S_F1: begin
        mul_a = swso_pkg::MUL_W'(len_r);
        mul_b = s2_r[axis_r][31:0];
      end
      S_F2: begin
        mul_a = swso_pkg::MUL_W'(len_r);
        mul_b = swso_pkg::MUL_W'(s2_r[axis_r][S2W-1:32]);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = evaluate ? S_LIM0 : S_DONE;
      S_LIM0:  state_nxt = S_LIM1;
      S_LIM1:  state_nxt = S_LIM2;
      S_LIM2:  state_nxt = S_LIM3;
      S_LIM3:  state_nxt = S_LIM4;
      S_LIM4:  state_nxt = S_SQ;
      S_SQ:    if (last_elem) state_nxt = S_F0;
      S_F0:    state_nxt = S_F1;
      S_F1:    state_nxt = S_F2;
      S_F2:    state_nxt = S_F3;
      S_F3:    state_nxt = S_F4;
      S_F4:    state_nxt = (axis_r == 2'd2) ? S_DONE : S_F0;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  swso_ram #(
    .DEPTH (WINDOW),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .we      (accept),
    .waddr   (wslot),
    .wdata   ({in_point_z, in_point_y, in_point_x}),
    .raddr   (rd_addr_nxt),
    .rdata_r (row_r)
  );

  swso_mul u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  // Datapath
  always_ff @(posedge clk) begin
    rd_addr_r <= rd_addr_nxt;
    acc_sel_r <= sub_r;
    if (accept) begin
      pt_x_r <= in_point_x;
      pt_y_r <= in_point_y;
      pt_z_r <= in_point_z;
      rb_x_r <= in_robot_x;
      rb_y_r <= in_robot_y;
      rb_z_r <= in_robot_z;
      len_r  <= len_eff;
      cnt_r  <= '0;
      sub_r  <= '0;
      axis_r <= '0;
      for (int i = 0; i < 3; i++) begin
        s1_r[i] <= '0;
        s2_r[i] <= '0;
      end
    end else if (acc_en_r) begin
      s2_r[acc_sel_r] <= s2_r[acc_sel_r] + S2W'(prod_r[47:0]);
    end
    case (state_r)
      S_LIM1: tt_r  <= prod_r[45:0];
      S_LIM2: nn_r  <= prod_r[15:0];
      S_LIM3: lim_r <= prod_r;
      S_LIM4: lim_r <= lim_r + {prod_r[31:0], 32'b0};
      S_SQ: begin
        s1_r[sub_r] <= s1_r[sub_r] + S1W'(v_s);
        if (sub_r == 2'd2) begin
          sub_r <= '0;
          cnt_r <= cnt_r + CW'(1);
        end else begin
          sub_r <= sub_r + 2'd1;
        end
      end
      S_F1:    cmp_r  <= lim_r + prod_r;
      S_F2:    sp_r   <= prod_r;
      S_F3:    sp_r   <= sp_r + {prod_r[31:0], 32'b0};
      S_F4:    axis_r <= axis_r + 2'd1;
      default: ;
    endcase
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      window_len_r <= swso_pkg::WINDOW_LEN_RST;
      thresh_r     <= swso_pkg::STILL_THRESHOLD_RST;
      fill_r       <= '0;
      oldest_r     <= '0;
      off_x_r      <= '0;
      off_y_r      <= '0;
      off_z_r      <= '0;
      out_valid_r  <= 1'b0;
      upd_r        <= 1'b0;
      still_r      <= 1'b0;
      acc_en_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      acc_en_r <= (state_r == S_SQ);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == swso_pkg::REG_WINDOW_LEN) begin
          window_len_r <= pwdata[swso_pkg::LEN_W-1:0];
        end else begin
          thresh_r <= pwdata[swso_pkg::THR_W-1:0];
        end
      end
      if (accept) begin
        if (evaluate) begin
          fill_r   <= len_eff - CW'(1);
          oldest_r <= oldest3;
          still_r  <= 1'b1;
        end else begin
          fill_r  <= fill_add;
          still_r <= 1'b0;
        end
      end
      if (state_r == S_F4 && !(sp_r < cmp_r)) begin
        still_r <= 1'b0;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
        upd_r       <= still_r;
        if (still_r) begin
          off_x_r  <= swso_pkg::OFF_W'(rb_x_r) - swso_pkg::OFF_W'(pt_x_r);
          off_y_r  <= swso_pkg::OFF_W'(rb_y_r) - swso_pkg::OFF_W'(pt_y_r);
          off_z_r  <= swso_pkg::OFF_W'(rb_z_r) - swso_pkg::OFF_W'(pt_z_r);
          fill_r   <= '0;
          oldest_r <= '0;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_offset_updated = upd_r;
  assign out_offset_x       = off_x_r;
  assign out_offset_y       = off_y_r;
  assign out_offset_z       = off_z_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_LIM0 || state_r == S_DONE))
    else $error("request taken without leaving idle");

  a_elem_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |-> (cnt_r < len_r))
    else $error("element count beyond window length");

  a_acc_follows_square: assert property (@(posedge clk) disable iff (!rst_n)
    acc_en_r |-> ($past(state_r) == S_SQ))
    else $error("square accumulated outside the element walk");

  a_still_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free && still_r) |=>
      (fill_r == '0 && oldest_r == '0 && upd_r && out_valid_r))
    else $error("stillness did not empty the window");

  a_fill_below_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (32'(fill_r) < WINDOW))
    else $error("window count out of range at idle");

endmodule

// ===== tb/sv/sliding_window_stillness_offset_tb.sv =====
// Testbench for the sliding-window stillness offset block: directed and random requests,
// register writes over the APB-style port, random gaps on the input and stalls on the output.
// Depends on swso_pkg and sliding_window_stillness_offset; checks against its own window model.
`timescale 1ns / 100ps

module sliding_window_stillness_offset_tb;

  localparam int WIN_DEPTH = 16;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES = 3 * WIN_DEPTH + 21 + 8;
  localparam longint CYCLE_LIMIT = 1_000_000;
  localparam swso_pkg::coord_t COORD_MAX = 24'sh7FFFFF;
  localparam swso_pkg::coord_t COORD_MIN = 24'sh800000;
  localparam logic [swso_pkg::THR_W-1:0] THR_MAX = 23'h7FFFFF;

  typedef struct packed {
    swso_pkg::coord_t px;
    swso_pkg::coord_t py;
    swso_pkg::coord_t pz;
    swso_pkg::coord_t rx;
    swso_pkg::coord_t ry;
    swso_pkg::coord_t rz;
  } track_req_t;

  typedef struct packed {
    logic              updated;
    swso_pkg::offset_t ox;
    swso_pkg::offset_t oy;
    swso_pkg::offset_t oz;
  } offset_rec_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  swso_pkg::coord_t            in_point_x, in_point_y, in_point_z;
  swso_pkg::coord_t            in_robot_x, in_robot_y, in_robot_z;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_offset_updated;
  swso_pkg::offset_t           out_offset_x, out_offset_y, out_offset_z;
  logic                        psel, penable, pwrite;
  logic [swso_pkg::CFG_AW-1:0] paddr;
  logic [swso_pkg::CFG_DW-1:0] pwdata;
  logic [swso_pkg::CFG_DW-1:0] prdata;
  logic                        pready;

  // window model state
  swso_pkg::coord_t           win_pts [WIN_DEPTH][3];
  int unsigned                win_fill;
  int unsigned                win_head;
  swso_pkg::offset_t          held_off [3];
  logic [swso_pkg::LEN_W-1:0] len_cfg;
  logic [swso_pkg::THR_W-1:0] thr_cfg;

  offset_rec_t offset_due_q [$];
  int          miscompare_count;
  int          items_sent;
  longint      cycle_count;
  bit          quiet;
  bit          hold_off;

  sliding_window_stillness_offset #(
    .WINDOW(WIN_DEPTH)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_point_z        (in_point_z),
    .in_robot_x        (in_robot_x),
    .in_robot_y        (in_robot_y),
    .in_robot_z        (in_robot_z),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_offset_updated(out_offset_updated),
    .out_offset_x      (out_offset_x),
    .out_offset_y      (out_offset_y),
    .out_offset_z      (out_offset_z),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int eff_window();
    if (len_cfg < 2) return 2;
    if (len_cfg > WIN_DEPTH) return WIN_DEPTH;
    return int'(len_cfg);
  endfunction

  function automatic bit axis_quiet(int ax, int n);
    longint          s1, v;
    longint unsigned s2, a1, spread, thr, lim, nl;
    s1 = 0;
    s2 = 0;
    nl = 64'(n);
    for (int i = 0; i < n; i++) begin
      v = longint'(win_pts[(win_head + i) % WIN_DEPTH][ax]);
      s1 += v;
      s2 += longint'(v * v);
    end
    a1 = (s1 < 0) ? -s1 : s1;
    spread = nl * s2 - a1 * a1;
    thr = 64'(thr_cfg);
    lim = thr * thr * nl * (nl - 64'd1);
    return spread < lim;
  endfunction

  function automatic offset_rec_t window_step(track_req_t r);
    swso_pkg::coord_t p [3];
    int               n;
    int unsigned      slot;
    bit               still;
    offset_rec_t      res;
    p[0] = r.px;
    p[1] = r.py;
    p[2] = r.pz;
    n = eff_window();
    res.updated = 1'b0;
    if (win_fill >= WIN_DEPTH) begin
      win_head = (win_head + 1) % WIN_DEPTH;
      win_fill = WIN_DEPTH - 1;
    end
    slot = (win_head + win_fill) % WIN_DEPTH;
    for (int a = 0; a < 3; a++) win_pts[slot][a] = p[a];
    win_fill++;
    if (win_fill >= n) begin
      // drop surplus points left over from a longer window
      win_head = (win_head + win_fill - n) % WIN_DEPTH;
      still = axis_quiet(0, n) && axis_quiet(1, n) && axis_quiet(2, n);
      win_head = (win_head + 1) % WIN_DEPTH;
      win_fill = n - 1;
      if (still) begin
        held_off[0] = swso_pkg::offset_t'(r.rx) - swso_pkg::offset_t'(r.px);
        held_off[1] = swso_pkg::offset_t'(r.ry) - swso_pkg::offset_t'(r.py);
        held_off[2] = swso_pkg::offset_t'(r.rz) - swso_pkg::offset_t'(r.pz);
        win_fill = 0;
        win_head = 0;
        res.updated = 1'b1;
      end
    end
    res.ox = held_off[0];
    res.oy = held_off[1];
    res.oz = held_off[2];
    return res;
  endfunction

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic track_req_t mk_req(input swso_pkg::coord_t px, py, pz, rx, ry, rz);
    track_req_t r;
    r.px = px;
    r.py = py;
    r.pz = pz;
    r.rx = rx;
    r.ry = ry;
    r.rz = rz;
    return r;
  endfunction

  function automatic track_req_t noise_req();
    return mk_req(swso_pkg::coord_t'($urandom), swso_pkg::coord_t'($urandom),
                  swso_pkg::coord_t'($urandom), swso_pkg::coord_t'($urandom),
                  swso_pkg::coord_t'($urandom), swso_pkg::coord_t'($urandom));
  endfunction

  function automatic swso_pkg::coord_t jitter(swso_pkg::coord_t base, int unsigned spread);
    longint v;
    v = longint'(base) + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
    if (v > longint'(COORD_MAX)) v = longint'(COORD_MAX);
    if (v < longint'(COORD_MIN)) v = longint'(COORD_MIN);
    return swso_pkg::coord_t'(v);
  endfunction

  function automatic int unsigned pick_spread();
    int unsigned s;
    if (thr_cfg == 0) return $urandom_range(0, 64);
    s = 32'(thr_cfg) * $urandom_range(0, 8) / 4;
    return (s > 24'hFFFFFF) ? 24'hFFFFFF : s;
  endfunction

  task automatic offer_point(input track_req_t r);
    int          gap;
    offset_rec_t due;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_point_x <= r.px;
    in_point_y <= r.py;
    in_point_z <= r.pz;
    in_robot_x <= r.rx;
    in_robot_y <= r.ry;
    in_robot_z <= r.rz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due = window_step(r);
    offset_due_q = {offset_due_q, due};
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (offset_due_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic sel, input logic [swso_pkg::CFG_DW-1:0] val);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == swso_pkg::REG_WINDOW_LEN) begin
      len_cfg = val[swso_pkg::LEN_W-1:0];
    end else begin
      thr_cfg = val[swso_pkg::THR_W-1:0];
    end
  endtask

  task automatic still_run(input int count, input int unsigned spread);
    swso_pkg::coord_t bx, by, bz;
    track_req_t       r;
    bx = swso_pkg::coord_t'($urandom);
    by = swso_pkg::coord_t'($urandom);
    bz = swso_pkg::coord_t'($urandom);
    repeat (count) begin
      r = noise_req();
      r.px = jitter(bx, spread);
      r.py = jitter(by, spread);
      r.pz = jitter(bz, spread);
      offer_point(r);
    end
  endtask

  task automatic test_directed();
    // partial window at reset defaults
    offer_point(mk_req('0, '0, '0, '0, '0, '0));
    offer_point(mk_req(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    offer_point(mk_req(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    // shorten the window below its current fill, then extreme offsets
    cfg_write(swso_pkg::REG_WINDOW_LEN, 32'd2);
    repeat (2) offer_point(mk_req(COORD_MAX, COORD_MAX, COORD_MAX,
                                  COORD_MIN, COORD_MIN, COORD_MIN));
    repeat (2) offer_point(mk_req(COORD_MIN, COORD_MIN, COORD_MIN,
                                  COORD_MAX, COORD_MAX, COORD_MAX));
    // zero threshold never latches
    cfg_write(swso_pkg::REG_STILL_THRESHOLD, 32'd0);
    repeat (3) offer_point(mk_req(24'sd1, 24'sd1, 24'sd1, 24'sd5, 24'sd5, 24'sd5));
    cfg_write(swso_pkg::REG_STILL_THRESHOLD, swso_pkg::CFG_DW'(THR_MAX));
    offer_point(mk_req(COORD_MIN, COORD_MAX, COORD_MIN, 24'sd7, 24'sd7, 24'sd7));
    offer_point(mk_req(COORD_MAX, COORD_MIN, COORD_MAX, 24'sd9, 24'sd9, 24'sd9));
    offer_point(mk_req(24'sd100, -24'sd100, 24'sd0, 24'sd3, -24'sd3, 24'sd0));
    // out-of-range window lengths
    cfg_write(swso_pkg::REG_WINDOW_LEN, 32'd0);
    repeat (2) offer_point(mk_req(-24'sd5, 24'sd6, -24'sd7, 24'sd50, 24'sd60, 24'sd70));
    cfg_write(swso_pkg::REG_WINDOW_LEN, 32'd1);
    repeat (2) offer_point(mk_req(24'sd42, 24'sd42, 24'sd42,
                                  -24'sd42, -24'sd42, -24'sd42));
    cfg_write(swso_pkg::REG_WINDOW_LEN, 32'd31);
    repeat (3) offer_point(mk_req(24'sd11, 24'sd12, 24'sd13, 24'sd14, 24'sd15, 24'sd16));
    cfg_write(swso_pkg::REG_STILL_THRESHOLD, swso_pkg::CFG_DW'(swso_pkg::STILL_THRESHOLD_RST));
  endtask

  task automatic test_window_shrink();
    cfg_write(swso_pkg::REG_WINDOW_LEN, 32'd16);
    repeat (9) offer_point(noise_req());
    cfg_write(swso_pkg::REG_WINDOW_LEN, 32'd4);
    still_run(4, 100);
    repeat (2) offer_point(noise_req());
    cfg_write(swso_pkg::REG_WINDOW_LEN, 32'd8);
    still_run(8, 200);
  endtask

  task automatic test_back_pressure();
    quiet = 1'b1;
    hold_off = 1'b1;
    still_run(12, 50);
    quiet = 1'b0;
  endtask

  task automatic test_random();
    int r;
    int target;
    while (items_sent < 1500) begin
      r = $urandom_range(0, 99);
      if (r < 25) begin
        cfg_write(swso_pkg::REG_WINDOW_LEN, 32'd2);
      end else if (r < 35) begin
        cfg_write(swso_pkg::REG_WINDOW_LEN, 32'd16);
      end else if (r < 45) begin
        cfg_write(swso_pkg::REG_WINDOW_LEN, $urandom_range(0, 31));
      end else begin
        cfg_write(swso_pkg::REG_WINDOW_LEN, $urandom_range(3, 8));
      end
      r = $urandom_range(0, 99);
      if (r < 10) begin
        cfg_write(swso_pkg::REG_STILL_THRESHOLD, 32'd0);
      end else if (r < 18) begin
        cfg_write(swso_pkg::REG_STILL_THRESHOLD, swso_pkg::CFG_DW'(THR_MAX));
      end else if (r < 45) begin
        cfg_write(swso_pkg::REG_STILL_THRESHOLD,
                  swso_pkg::CFG_DW'(swso_pkg::STILL_THRESHOLD_RST));
      end else begin
        cfg_write(swso_pkg::REG_STILL_THRESHOLD, $urandom_range(1, 40000));
      end
      quiet = ($urandom_range(0, 5) == 0);
      target = items_sent + 90;
      while (items_sent < target) begin
        if ($urandom_range(0, 9) < 8) begin
          still_run(eff_window() + $urandom_range(0, 3), pick_spread());
        end else begin
          repeat ($urandom_range(1, 4)) offer_point(noise_req());
        end
      end
      quiet = 1'b0;
    end
  endtask

  initial begin : rx_side
    int run_left;
    bit stalled;
    bit held;
    run_left = 0;
    held = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        out_stall <= 1'b1;
        for (int k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge clk);
        held = 1'b1;
        run_left = 0;
        out_stall <= 1'b0;
      end else if (run_left == 0) begin
        stalled = !quiet && ($urandom_range(0, 99) < 30);
        run_left = stalled ? idle_len() + 1 : $urandom_range(1, 20);
        out_stall <= stalled;
      end else begin
        run_left--;
      end
    end
  end

  always @(posedge clk) begin : result_check
    offset_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (offset_due_q.size() == 0) begin
        $error("offset result with no request outstanding");
        miscompare_count++;
      end else begin
        want = offset_due_q.pop_front();
        if (out_offset_updated !== want.updated) begin
          $error("offset_updated mismatch: expected %0d, got %0d",
                 want.updated, out_offset_updated);
          miscompare_count++;
        end
        if (out_offset_x !== want.ox) begin
          $error("offset_x mismatch: expected %0d, got %0d", want.ox, out_offset_x);
          miscompare_count++;
        end
        if (out_offset_y !== want.oy) begin
          $error("offset_y mismatch: expected %0d, got %0d", want.oy, out_offset_y);
          miscompare_count++;
        end
        if (out_offset_z !== want.oz) begin
          $error("offset_z mismatch: expected %0d, got %0d", want.oz, out_offset_z);
          miscompare_count++;
        end
      end
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_point_x <= '0;
    in_point_y <= '0;
    in_point_z <= '0;
    in_robot_x <= '0;
    in_robot_y <= '0;
    in_robot_z <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    items_sent = 0;
    quiet = 1'b0;
    hold_off = 1'b0;
    win_fill = 0;
    win_head = 0;
    held_off[0] = '0;
    held_off[1] = '0;
    held_off[2] = '0;
    len_cfg = swso_pkg::WINDOW_LEN_RST;
    thr_cfg = swso_pkg::STILL_THRESHOLD_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_window_shrink();
    test_back_pressure();
    test_random();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (miscompare_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/swso_pkg.sv
sv/swso_ram.sv
sv/swso_mul.sv
sv/sliding_window_stillness_offset.sv
tb/sv/sliding_window_stillness_offset_tb.sv
